/* rtl/rgba_box_downsample_2x2_core_assert.svh */
// Assertion macros for the 2x2 box downsampler.
`ifndef RGBA_BOX_DOWNSAMPLE_2X2_CORE_ASSERT_SVH
`define RGBA_BOX_DOWNSAMPLE_2X2_CORE_ASSERT_SVH

`ifndef SYNTH
`define RBD_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbd check failed");
`define RBD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbd check failed");
`else
`define RBD_ASSERT_SAME(name, ante, cons)
`define RBD_ASSERT_NEXT(name, ante, cons)
`endif

`endif

/* rtl/rbd_pkg.sv */
// Shared constants and types for the 2x2 box downsampler.
`timescale 1ns / 1ps
package rbd_pkg;

  localparam int MaxWidth  = 4096;
  localparam int MaxHeight = 4096;
  localparam int LineDepth = MaxWidth / 2;
  localparam int SlotW     = $clog2(LineDepth);
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int SizeW     = 13;
  localparam int Channels  = 4;
  localparam int ChanW     = 8;
  localparam int PairW     = ChanW + 1;
  localparam int LineW     = Channels * PairW;
  localparam int PixW      = Channels * ChanW;

  localparam logic RegImageWidth  = 1'b0;
  localparam logic RegImageHeight = 1'b1;

  typedef struct packed {
    logic             even_col;
    logic             write_line;
    logic             emit;
    logic             last;
    logic [SlotW-1:0] slot;
  } pos_t;

endpackage

/* rtl/rbd_ctrl.sv */
// Size registers and raster position tracking for the 2x2 box downsampler.
`timescale 1ns / 1ps
module rbd_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic                      cfg_index,
  input  logic [rbd_pkg::SizeW-1:0] cfg_data,
  input  logic                      step,
  output rbd_pkg::pos_t             pos
);

  logic [rbd_pkg::SizeW-1:0] image_width;
  logic [rbd_pkg::SizeW-1:0] image_height;
  logic [rbd_pkg::ColW-1:0]  col;
  logic [rbd_pkg::RowW-1:0]  row;
  logic [rbd_pkg::ColW-1:0]  col_next;
  logic [rbd_pkg::RowW-1:0]  row_next;

  logic [rbd_pkg::SizeW-1:0] w_eff;
  logic [rbd_pkg::SizeW-1:0] h_eff;
  logic [rbd_pkg::SizeW-1:0] w_even;
  logic [rbd_pkg::SizeW-1:0] h_even;
  logic [rbd_pkg::ColW-1:0]  col_cur;
  logic [rbd_pkg::RowW-1:0]  row_cur;
  logic [rbd_pkg::SizeW-1:0] col_inc;
  logic [rbd_pkg::SizeW-1:0] row_inc;
  logic                      pair_row;

  always_comb begin
    if (image_width < rbd_pkg::SizeW'(2)) begin
      w_eff = rbd_pkg::SizeW'(2);
    end else if (image_width > rbd_pkg::SizeW'(rbd_pkg::MaxWidth)) begin
      w_eff = rbd_pkg::SizeW'(rbd_pkg::MaxWidth);
    end else begin
      w_eff = image_width;
    end
    if (image_height < rbd_pkg::SizeW'(2)) begin
      h_eff = rbd_pkg::SizeW'(2);
    end else if (image_height > rbd_pkg::SizeW'(rbd_pkg::MaxHeight)) begin
      h_eff = rbd_pkg::SizeW'(rbd_pkg::MaxHeight);
    end else begin
      h_eff = image_height;
    end
    w_even   = {w_eff[rbd_pkg::SizeW-1:1], 1'b0};
    h_even   = {h_eff[rbd_pkg::SizeW-1:1], 1'b0};
    col_cur  = (rbd_pkg::SizeW'(col) >= w_eff) ? '0 : col;
    row_cur  = (rbd_pkg::SizeW'(row) >= h_eff) ? '0 : row;
    pair_row = rbd_pkg::SizeW'(row_cur) < h_even;
    col_inc  = rbd_pkg::SizeW'(col_cur) + rbd_pkg::SizeW'(1);
    row_inc  = rbd_pkg::SizeW'(row_cur) + rbd_pkg::SizeW'(1);
    if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = (row_inc >= h_eff) ? '0 : row_inc[rbd_pkg::RowW-1:0];
    end else begin
      col_next = col_inc[rbd_pkg::ColW-1:0];
      row_next = row_cur;
    end
    pos.even_col   = !col_cur[0];
    pos.write_line = col_cur[0] && pair_row && !row_cur[0];
    pos.emit       = col_cur[0] && pair_row && row_cur[0];
    pos.last       = (rbd_pkg::SizeW'(col_cur) == w_even - rbd_pkg::SizeW'(1))
                  && (rbd_pkg::SizeW'(row_cur) == h_even - rbd_pkg::SizeW'(1));
    pos.slot       = col_cur[rbd_pkg::SlotW:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= rbd_pkg::SizeW'(2);
      image_height <= rbd_pkg::SizeW'(2);
      col          <= '0;
      row          <= '0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          rbd_pkg::RegImageWidth:  image_width  <= cfg_data;
          rbd_pkg::RegImageHeight: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (step) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

endmodule

/* rtl/rbd_linebuf.sv */
// Line buffer of pair sums from even rows.
`timescale 1ns / 1ps
module rbd_linebuf (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [rbd_pkg::SlotW-1:0] wr_addr,
  input  logic [rbd_pkg::LineW-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [rbd_pkg::SlotW-1:0] rd_addr,
  output logic [rbd_pkg::LineW-1:0] rd_data
);

  logic [rbd_pkg::LineW-1:0] mem [rbd_pkg::LineDepth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/rbd_lane.sv */
// One color channel: horizontal pair sum and rounded 2x2 mean.
`timescale 1ns / 1ps
module rbd_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load_left,
  input  logic                      load_pair,
  input  logic [rbd_pkg::ChanW-1:0] pixel,
  input  logic [rbd_pkg::PairW-1:0] above,
  output logic [rbd_pkg::PairW-1:0] pair_sum,
  output logic [rbd_pkg::ChanW-1:0] mean
);

  logic [rbd_pkg::ChanW-1:0] left;
  logic [rbd_pkg::PairW-1:0] pair;
  logic [rbd_pkg::PairW:0]   total;

  assign pair_sum = rbd_pkg::PairW'(left) + rbd_pkg::PairW'(pixel);
  assign total    = (rbd_pkg::PairW+1)'(pair) + (rbd_pkg::PairW+1)'(above)
                  + (rbd_pkg::PairW+1)'(2);
  assign mean     = total[rbd_pkg::PairW:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load_left) begin
      left <= pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pair) begin
      pair <= pair_sum;
    end
  end

endmodule

/* rtl/rgba_box_downsample_2x2_core.sv */
// Top level of the 2x2 box downsampler: lanes, line buffer and output merge.
// A result passes through the holding stage and then the output register after the beat of its lower-right pixel.
// Throughput: one pixel per cycle while the output does not stall, set by the single line buffer access per beat.
// An output register plus one holding stage let one more result in while the output stalls.
// Reset (rst, synchronous): position to zero, sizes to 2x2, pipeline empty.
// The line buffer is not cleared; each entry is read only after its even row writes it.
`timescale 1ns / 1ps
`include "rgba_box_downsample_2x2_core_assert.svh"
module rgba_box_downsample_2x2_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic                      cfg_index,
  input  logic [rbd_pkg::SizeW-1:0] cfg_data,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [rbd_pkg::PixW-1:0]  s_axis_tdata,   // in_red, in_green, in_blue, in_alpha
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [rbd_pkg::PixW-1:0]  m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
  output logic                      m_axis_tlast
);

  rbd_pkg::pos_t             pos;
  logic                      accept;
  logic                      s1_load;
  logic                      s1_move;
  logic                      s1_valid;
  logic                      s1_last;
  logic [rbd_pkg::LineW-1:0] wr_data;
  logic [rbd_pkg::LineW-1:0] above;
  logic [rbd_pkg::PixW-1:0]  means;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s1_load       = accept && pos.emit;
  assign s1_move       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !rst && (!s1_valid || s1_move);

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .pos       (pos)
  );

  rbd_linebuf u_linebuf (
    .clk     (clk),
    .wr_en   (accept && pos.write_line),
    .wr_addr (pos.slot),
    .wr_data (wr_data),
    .rd_en   (s1_load),
    .rd_addr (pos.slot),
    .rd_data (above)
  );

  for (genvar c = 0; c < rbd_pkg::Channels; c++) begin : g_lane
    rbd_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .load_left (accept && pos.even_col),
      .load_pair (s1_load),
      .pixel     (s_axis_tdata[c*rbd_pkg::ChanW +: rbd_pkg::ChanW]),
      .above     (above[c*rbd_pkg::PairW +: rbd_pkg::PairW]),
      .pair_sum  (wr_data[c*rbd_pkg::PairW +: rbd_pkg::PairW]),
      .mean      (means[c*rbd_pkg::ChanW +: rbd_pkg::ChanW])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_last <= pos.last;
    end
    if (s1_move) begin
      m_axis_tdata <= means;
      m_axis_tlast <= s1_last;
    end
  end

  `RBD_ASSERT_SAME(a_ready_when_empty, !s1_valid, s_axis_tready)
  `RBD_ASSERT_NEXT(a_hold_stage, s1_valid && !s_axis_tready, s1_valid)
  `RBD_ASSERT_NEXT(a_fill_output, s1_valid && !m_axis_tvalid, m_axis_tvalid)
  `RBD_ASSERT_SAME(a_emit_odd_only, s1_load, !pos.even_col && !pos.write_line)

endmodule
